// ===== sv/circle_outline_rasterizer_macros.svh =====
// Assertion macros shared by the circle outline rasterizer RTL.
`ifndef CIRCLE_OUTLINE_RASTERIZER_MACROS_SVH
`define CIRCLE_OUTLINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define COR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define COR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cor_pkg.sv =====
// Package with the shared types and constants of the circle outline rasterizer.
`default_nettype none

package cor_pkg;

    localparam int COORD_BITS_DEF = 15;
    localparam int QUEUE_DEPTH    = 2;
    localparam int OCT_BITS       = 3;

    localparam logic FUNC_ADVANCE = 1'b0;
    localparam logic FUNC_START   = 1'b1;

    localparam logic [OCT_BITS-1:0] OCT_FIRST = 3'd0;
    localparam logic [OCT_BITS-1:0] OCT_LAST  = 3'd7;

    typedef struct packed {
        logic idle;
        logic done;
    } job_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/cor_front.sv =====
// Front end: accepts words, keeps the circle state and runs one Andres iteration per word while a circle is active.
`default_nettype none

module cor_front
    import cor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         func,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic        [COORD_BITS-2:0] radius,
    output logic                              job_push,
    input  wire logic                         job_full,
    output job_ctrl_t                         job_ctrl,
    output logic signed [COORD_BITS-1:0]      job_cx,
    output logic signed [COORD_BITS-1:0]      job_cy,
    output logic signed [COORD_BITS-1:0]      job_x,
    output logic signed [COORD_BITS-1:0]      job_y
);

    localparam int DW = COORD_BITS + 2;
    localparam logic signed [DW-1:0]         D_ONE = DW'(1);
    localparam logic signed [DW-1:0]         D_TWO = DW'(2);
    localparam logic signed [COORD_BITS-1:0] C_ONE = COORD_BITS'(1);

    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic        [COORD_BITS-2:0] r_reg, r_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;
    logic signed [DW-1:0]         d_reg, d_next;
    logic                         active_reg, active_next;

    logic                         start;
    logic                         accept;
    logic                         act;
    logic signed [COORD_BITS-1:0] cx_cur, cy_cur, x_cur, y_cur, x_new, y_new;
    logic        [COORD_BITS-2:0] r_cur;
    logic signed [DW-1:0]         d_cur, d_new, two_x, two_y, two_rmy, r_ext;
    logic                         done;

    assign in_ready = !job_full;
    assign accept   = in_valid && !job_full;
    assign job_push = accept;

    always_comb
    begin
        start  = (func == FUNC_START);
        cx_cur = start ? center_x : cx_reg;
        cy_cur = start ? center_y : cy_reg;
        r_cur  = start ? radius : r_reg;
        x_cur  = start ? '0 : x_reg;
        y_cur  = start ? $signed({1'b0, radius}) : y_reg;
        d_cur  = start ? ($signed({3'b000, radius}) - D_ONE) : d_reg;
        act    = start || active_reg;

        two_x   = DW'(x_cur) <<< 1;
        two_y   = DW'(y_cur) <<< 1;
        r_ext   = $signed({3'b000, r_cur});
        two_rmy = (r_ext - DW'(y_cur)) <<< 1;

        // Three-way Andres step: move right, move down, or move diagonally.
        if (d_cur >= two_x)
        begin
            d_new = d_cur - two_x - D_ONE;
            x_new = x_cur + C_ONE;
            y_new = y_cur;
        end
        else if (d_cur < two_rmy)
        begin
            d_new = d_cur + two_y - D_ONE;
            x_new = x_cur;
            y_new = y_cur - C_ONE;
        end
        else
        begin
            d_new = d_cur + two_y - two_x - D_TWO;
            x_new = x_cur + C_ONE;
            y_new = y_cur - C_ONE;
        end
        done = (y_new < x_new);

        job_ctrl.idle = !act;
        job_ctrl.done = act && done;
        job_cx        = cx_cur;
        job_cy        = cy_cur;
        job_x         = x_cur;
        job_y         = y_cur;

        cx_next     = cx_reg;
        cy_next     = cy_reg;
        r_next      = r_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        active_next = active_reg;
        if (accept)
        begin
            if (start)
            begin
                cx_next = center_x;
                cy_next = center_y;
                r_next  = radius;
            end
            if (act)
            begin
                x_next      = x_new;
                y_next      = y_new;
                d_next      = d_new;
                active_next = !done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        r_reg  <= r_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        d_reg  <= d_next;
    end

endmodule

`default_nettype wire

// ===== sv/cor_queue.sv =====
// Short first-in first-out queue of iteration jobs between the front and the back end.
`default_nettype none

module cor_queue
    import cor_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop && !empty)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cor_back.sv =====
// Back end: walks the eight mirrored positions of each circle job, or one idle word, into a registered output word.
`default_nettype none

module cor_back
    import cor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         job_valid,
    output logic                              job_pop,
    input  wire job_ctrl_t                    job_ctrl,
    input  wire logic signed [COORD_BITS-1:0] job_cx,
    input  wire logic signed [COORD_BITS-1:0] job_cy,
    input  wire logic signed [COORD_BITS-1:0] job_x,
    input  wire logic signed [COORD_BITS-1:0] job_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS:0]        pixel_x,
    output logic signed [COORD_BITS:0]        pixel_y,
    output logic [OCT_BITS-1:0]               octant,
    output logic                              last,
    output logic                              circle_done,
    output logic                              idle
);

    localparam int PW = COORD_BITS + 1;

    logic [OCT_BITS-1:0]   oct_reg, oct_next;
    logic                  valid_reg, valid_next;
    logic signed [PW-1:0]  px_reg, py_reg;
    logic [OCT_BITS-1:0]   octant_reg;
    logic                  last_reg, done_reg, idle_reg;

    logic                  load;
    logic                  final_word;
    logic signed [PW-1:0]  cxe, cye, ae, be, px_val, py_val;

    assign out_valid   = valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign octant      = octant_reg;
    assign last        = last_reg;
    assign circle_done = done_reg;
    assign idle        = idle_reg;

    always_comb
    begin
        load       = job_valid && (!valid_reg || out_ready);
        final_word = job_ctrl.idle || (oct_reg == OCT_LAST);
        job_pop    = load && final_word;

        // Bit 0 swaps x and y, bit 1 negates the x offset, bit 2 the y offset.
        cxe    = PW'(job_cx);
        cye    = PW'(job_cy);
        ae     = oct_reg[0] ? PW'(job_y) : PW'(job_x);
        be     = oct_reg[0] ? PW'(job_x) : PW'(job_y);
        px_val = oct_reg[1] ? (cxe - ae) : (cxe + ae);
        py_val = oct_reg[2] ? (cye - be) : (cye + be);

        oct_next   = oct_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            oct_next   = final_word ? OCT_FIRST : oct_reg + OCT_BITS'(1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg   <= OCT_FIRST;
            valid_reg <= 1'b0;
        end
        else
        begin
            oct_reg   <= oct_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (job_ctrl.idle)
            begin
                px_reg     <= '0;
                py_reg     <= '0;
                octant_reg <= OCT_FIRST;
                last_reg   <= 1'b1;
                done_reg   <= 1'b0;
                idle_reg   <= 1'b1;
            end
            else
            begin
                px_reg     <= px_val;
                py_reg     <= py_val;
                octant_reg <= oct_reg;
                last_reg   <= (oct_reg == OCT_LAST);
                done_reg   <= (oct_reg == OCT_LAST) && job_ctrl.done;
                idle_reg   <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/circle_outline_rasterizer.sv =====
// Top level of the circle outline rasterizer: front end, job queue and back end.
`default_nettype none
`include "circle_outline_rasterizer_macros.svh"

// Circle outline rasterizer (Andres algorithm). A start word (func = 1) loads
// the center and radius and begins a new circle, dropping any circle still in
// progress; every word, start or advance, then runs one iteration and yields the
// eight mirrored pixels of the current (x, y) as eight output words, octant 0
// through 7, with last set on octant 7. Pixels repeated where x is zero or x
// equals y are still sent. The iteration that ends the circle also sets
// circle_done on its octant 7 word. An advance word with no circle running gives
// a single word with idle and last set and all pixel fields zero. Timing: the
// front end runs the iteration in the cycle the word is accepted and pushes the
// result into a two-entry job queue; the back end sends one output word per
// cycle while out_ready is high, from a registered output stage, so a circle
// word costs eight output words and an idle word one. The back end holds the
// job at the head of the queue until its last word is loaded; input words
// are taken back to back while the queue has room, and the first output word
// of a job passes through the job queue and then the output register. Pixel
// coordinates are exact sums, COORD_BITS + 1 bits wide.
module circle_outline_rasterizer
    import cor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         func,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic        [COORD_BITS-2:0] radius,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS:0]        pixel_x,
    output logic signed [COORD_BITS:0]        pixel_y,
    output logic [OCT_BITS-1:0]               octant,
    output logic                              last,
    output logic                              circle_done,
    output logic                              idle
);

    // A job holds the control flags, the center and the current (x, y).
    localparam int JOB_BITS = $bits(job_ctrl_t) + 4 * COORD_BITS;

    logic                         job_push;
    logic                         job_full;
    logic                         job_pop;
    logic                         job_empty;
    job_ctrl_t                    front_ctrl;
    logic signed [COORD_BITS-1:0] front_cx, front_cy, front_x, front_y;
    logic [JOB_BITS-1:0]          wr_job, rd_job;
    job_ctrl_t                    back_ctrl;
    logic signed [COORD_BITS-1:0] back_cx, back_cy, back_x, back_y;

    cor_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .job_push (job_push),
        .job_full (job_full),
        .job_ctrl (front_ctrl),
        .job_cx   (front_cx),
        .job_cy   (front_cy),
        .job_x    (front_x),
        .job_y    (front_y)
    );

    assign wr_job = {front_ctrl, front_cx, front_cy, front_x, front_y};

    cor_queue #(
        .WIDTH (JOB_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .wr_data (wr_job),
        .full    (job_full),
        .pop     (job_pop),
        .rd_data (rd_job),
        .empty   (job_empty)
    );

    assign {back_ctrl, back_cx, back_cy, back_x, back_y} = rd_job;

    cor_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!job_empty),
        .job_pop     (job_pop),
        .job_ctrl    (back_ctrl),
        .job_cx      (back_cx),
        .job_cy      (back_cy),
        .job_x       (back_x),
        .job_y       (back_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .octant      (octant),
        .last        (last),
        .circle_done (circle_done),
        .idle        (idle)
    );

    // An idle word is always a single, final word with octant zero.
    `COR_ASSERT_NOW(a_idle_word, out_valid && idle, last && !circle_done && octant == OCT_FIRST, "idle word malformed")

    // A circle word is final exactly on octant seven; circle_done only appears there.
    `COR_ASSERT_NOW(a_last_octant, out_valid && !idle, last == (octant == OCT_LAST), "last does not match octant")
    `COR_ASSERT_NOW(a_done_on_last, out_valid && circle_done, last && !idle, "circle_done off the final word")

    // A taken non-final circle word is followed by the next octant of the same item.
    `COR_ASSERT_NEXT(a_octant_order, out_valid && out_ready && !last, out_valid && !idle && octant == $past(octant) + 3'd1, "octant sequence broken")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the circle outline rasterizer.
`default_nettype none

// The testbench predicts every output word of the rasterizer from its own
// model of the Andres iteration. It checks the words in order against what
// the block sends. Stimulus runs as named tests in turn. First come a few
// directed words: idle advances, zero radius, extreme centers and radii,
// restart while a circle is running, and small circles run to the end.
// Then come random circles under different idle and stall mixes. The last
// test holds the output off for a long stretch so that the job queue fills
// and the input stalls.
module tb;
    import cor_pkg::*;

    localparam int COORD_BITS     = COORD_BITS_DEF;
    localparam int CENTER_MIN     = -(1 << (COORD_BITS - 1));
    localparam int CENTER_MAX     = (1 << (COORD_BITS - 1)) - 1;
    localparam int RADIUS_MAX     = (1 << (COORD_BITS - 1)) - 1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_PRINTED    = 30;

    // One expected output word.
    typedef struct {
        logic signed [COORD_BITS:0] px;
        logic signed [COORD_BITS:0] py;
        logic [OCT_BITS-1:0]        oct;
        logic                       last;
        logic                       done;
        logic                       idle;
    } pixel_word_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           func = FUNC_ADVANCE;
    logic signed [COORD_BITS-1:0]   center_x = '0;
    logic signed [COORD_BITS-1:0]   center_y = '0;
    logic        [COORD_BITS-2:0]   radius = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [COORD_BITS:0]     pixel_x;
    logic signed [COORD_BITS:0]     pixel_y;
    logic [OCT_BITS-1:0]            octant;
    logic                           last;
    logic                           circle_done;
    logic                           idle;

    // Outline words still to come from the block, oldest first.
    pixel_word_t pending_pixels[$];

    // Our copy of the circle state; center, radius and decision term at the widths of the block.
    logic signed [COORD_BITS-1:0]   ctr_x = '0;
    logic signed [COORD_BITS-1:0]   ctr_y = '0;
    logic        [COORD_BITS-2:0]   circ_rad = '0;
    logic        [COORD_BITS-2:0]   walk_x = '0;
    logic        [COORD_BITS-2:0]   walk_y = '0;
    logic signed [COORD_BITS+1:0]   walk_d = '0;
    logic                           circle_on = 1'b0;

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;

    circle_outline_rasterizer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .octant      (octant),
        .last        (last),
        .circle_done (circle_done),
        .idle        (idle)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Runs one Andres iteration on our copy of the state for an accepted word
    // and queues the words it must produce. A start reloads the circle first,
    // dropping whatever circle was running.
    function automatic void trace_iteration(input logic f,
                                            input logic signed [COORD_BITS-1:0] cx,
                                            input logic signed [COORD_BITS-1:0] cy,
                                            input logic [COORD_BITS-2:0] r);
        int x, y, d, rr, nx, ny, nd;
        int dx[8];
        int dy[8];
        bit fin;
        pixel_word_t w;
        if (f == FUNC_START)
        begin
            ctr_x     = cx;
            ctr_y     = cy;
            circ_rad  = r;
            walk_x    = '0;
            walk_y    = r;
            walk_d    = (COORD_BITS+2)'(int'(r) - 1);
            circle_on = 1'b1;
        end
        if (!circle_on)
        begin
            w = '{px: '0, py: '0, oct: OCT_FIRST, last: 1'b1, done: 1'b0, idle: 1'b1};
            pending_pixels.push_back(w);
            return;
        end
        x  = int'(walk_x);
        y  = int'(walk_y);
        d  = int'(walk_d);
        rr = int'(circ_rad);
        // Three-way choice: step right, step down, or step diagonally.
        if (d >= 2 * x)
        begin
            nd = d - (2 * x + 1);
            nx = x + 1;
            ny = y;
        end
        else if (d < 2 * (rr - y))
        begin
            nd = d + 2 * y - 1;
            nx = x;
            ny = y - 1;
        end
        else
        begin
            nd = d + 2 * (y - x - 1);
            nx = x + 1;
            ny = y - 1;
        end
        walk_x = (COORD_BITS-1)'(nx);
        walk_y = (COORD_BITS-1)'(ny);
        walk_d = (COORD_BITS+2)'(nd);
        fin = (ny < nx);
        if (fin)
            circle_on = 1'b0;
        // Mirror order: the eight octants as the block sends them.
        dx = '{x, y, -x, -y, x, y, -x, -y};
        dy = '{y, x, y, x, -y, -x, -y, -x};
        for (int k = 0; k < 8; k++)
        begin
            w.px   = (COORD_BITS+1)'(int'(ctr_x) + dx[k]);
            w.py   = (COORD_BITS+1)'(int'(ctr_y) + dy[k]);
            w.oct  = OCT_BITS'(k);
            w.last = (w.oct == OCT_LAST);
            w.done = w.last && fin;
            w.idle = 1'b0;
            pending_pixels.push_back(w);
        end
    endfunction

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got,
                     want);
    endtask

    // Offers one word and waits until the block takes it. Valid is left high so
    // that back-to-back words never lower and raise it in the same step; callers
    // drop it once a sequence is over.
    task automatic send_word(input logic f,
                             input logic signed [COORD_BITS-1:0] cx,
                             input logic signed [COORD_BITS-1:0] cy,
                             input logic [COORD_BITS-2:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        center_x <= cx;
        center_y <= cy;
        radius   <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        trace_iteration(f, cx, cy, r);
    endtask

    task automatic start_circle(input int cx, input int cy, input int r);
        send_word(FUNC_START, COORD_BITS'(cx), COORD_BITS'(cy), (COORD_BITS-1)'(r));
    endtask

    // Advance words carry random payload, which the block must ignore.
    task automatic advance_word();
        send_word(FUNC_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  (COORD_BITS-1)'($urandom));
    endtask

    // Advances the running circle until it finishes.
    task automatic finish_circle();
        while (circle_on)
            advance_word();
    endtask

    // Drops valid, waits for every expected word, then lets the pipe settle.
    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Advances with no circle yet must give a single idle word each.
    task automatic test_idle_advance();
        send_word(FUNC_ADVANCE, COORD_BITS'(CENTER_MAX), COORD_BITS'(CENTER_MIN),
                  (COORD_BITS-1)'(RADIUS_MAX));
        send_word(FUNC_ADVANCE, COORD_BITS'(CENTER_MIN), COORD_BITS'(CENTER_MAX), '0);
        drain_pixels();
    endtask

    // A zero radius puts all eight pixels on the center and ends at once.
    task automatic test_zero_radius();
        start_circle(CENTER_MIN, CENTER_MAX, 0);
        start_circle(CENTER_MAX, CENTER_MIN, 0);
        advance_word();
        drain_pixels();
    endtask

    // Largest radius at both corner centers, so the pixel sums reach the ends
    // of their range; the second start lands while the first circle runs.
    task automatic test_extreme_centers();
        start_circle(CENTER_MIN, CENTER_MIN, RADIUS_MAX);
        advance_word();
        advance_word();
        start_circle(CENTER_MAX, CENTER_MAX, RADIUS_MAX);
        advance_word();
        advance_word();
        drain_pixels();
    endtask

    // Small circles run to the end, with a restart in the middle of one, and
    // an advance after the end, which must be idle again.
    task automatic test_small_circles();
        start_circle(0, 0, 1);
        finish_circle();
        start_circle(-5, 7, 3);
        advance_word();
        start_circle(100, -200, 5);
        finish_circle();
        advance_word();
        drain_pixels();
    endtask

    // Mostly whole circles with random centers and small radii; some are cut
    // short by a new start, some have huge radii, and some words are bare
    // advances that may land while idle.
    task automatic test_random_circles(input int n_words, input int idle_pct,
                                       input int stall_in);
        int sent;
        int pick;
        int steps;
        int r;
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
        sent          = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(99) < 10)
            begin
                advance_word();
                sent++;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    r = $urandom_range(24);
                else if (pick < 90)
                    r = $urandom_range(60, 25);
                else
                    r = $urandom_range(RADIUS_MAX);
                start_circle($urandom, $urandom, r);
                sent++;
                steps = ($urandom_range(99) < 15) ? $urandom_range(6) : n_words;
                while (circle_on && steps > 0 && sent < n_words)
                begin
                    advance_word();
                    sent++;
                    steps--;
                end
            end
        end
        drain_pixels();
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the queue fills and in_ready must drop until the output drains.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b1;
        start_circle(-300, 250, 12);
        for (int i = 0; i < 11; i++)
            advance_word();
        drain_pixels();
    endtask

    // Receiver: random stalls, or a long counted hold when a test asks for one.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compares every accepted output word with the oldest expected one.
    always @(posedge clk)
    begin
        pixel_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("unexpected word, pixel_x", int'(pixel_x), 0);
            end
            else
            begin
                w = pending_pixels.pop_front();
                if (pixel_x !== w.px)
                    report_mismatch("pixel_x", int'(pixel_x), int'(w.px));
                if (pixel_y !== w.py)
                    report_mismatch("pixel_y", int'(pixel_y), int'(w.py));
                if (octant !== w.oct)
                    report_mismatch("octant", int'(octant), int'(w.oct));
                if (last !== w.last)
                    report_mismatch("last", int'(last), int'(w.last));
                if (circle_done !== w.done)
                    report_mismatch("circle_done", int'(circle_done), int'(w.done));
                if (idle !== w.idle)
                    report_mismatch("idle", int'(idle), int'(w.idle));
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles, %0d still expected",
                         WATCHDOG_LIMIT, pending_pixels.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_advance();
        test_zero_radius();
        test_extreme_centers();
        test_small_circles();

        test_random_circles(100, 0, 0);
        test_random_circles(100, 81, 0);
        test_random_circles(100, 0, 81);
        test_random_circles(100, 11, 11);
        test_output_backpressure();

        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
